// File: hdl/irc_line_tokenizer_classifier_core_assert.svh
// Assertion macros for the tokenizer/classifier modules.
`ifndef IRC_LINE_TOKENIZER_CLASSIFIER_CORE_ASSERT_SVH
`define IRC_LINE_TOKENIZER_CLASSIFIER_CORE_ASSERT_SVH
// Implication checked on every edge outside reset.
`define ILTC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ILTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: hdl/iltc_pkg.sv
// Types and constants shared by the IRC line tokenizer/classifier.
package iltc_pkg;
  localparam int unsigned ParamW = 7;

  typedef enum logic [3:0] {
    MODE_GAP   = 4'b0001,
    MODE_TOKEN = 4'b0010,
    MODE_TRAIL = 4'b0100,
    MODE_SKIP  = 4'b1000
  } scan_mode_t;

  localparam logic [4:0] ID_CAP     = 5'd0;
  localparam logic [4:0] ID_PING    = 5'd4;
  localparam logic [4:0] ID_UNKNOWN = 5'd14;

  localparam logic [2:0] SUB_NONE  = 3'd0;
  localparam logic [2:0] SUB_LS    = 3'd1;
  localparam logic [2:0] SUB_REQ   = 3'd2;
  localparam logic [2:0] SUB_END   = 3'd3;
  localparam logic [2:0] SUB_OTHER = 3'd4;

  localparam logic [2:0] RPL_DISPATCH = 3'd0;
  localparam logic [2:0] RPL_CAP_LS   = 3'd1;
  localparam logic [2:0] RPL_CAP_NAK  = 3'd2;
  localparam logic [2:0] RPL_451      = 3'd3;
  localparam logic [2:0] RPL_421      = 3'd4;
  localparam logic [2:0] RPL_NONE     = 3'd5;

  localparam logic [0:0] REG_NICK_MAX = 1'd0;
  localparam logic [0:0] REG_CHAN_MAX = 1'd1;

  // Line summary handed from the scanner to the classifier.
  typedef struct packed {
    logic [4:0]        cmd_id;
    logic [3:0]        sub_len;
    logic [3:0][7:0]   sub_chars;
    logic              has_param;
    logic [3:0]        params;
    logic              trailing;
    logic              nick_flag;
    logic              chan_flag;
    logic [ParamW-1:0] param_len;
    logic              registered;
    logic              overflow;
  } line_sum_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction
endpackage

// File: hdl/iltc_scanner.sv
// Front end: scans bytes, tracks tokens and builds the line summary.
module iltc_scanner #(
  parameter int unsigned MAX_LINE_BYTES = 512,
  parameter int unsigned CMD_CHARS      = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic [7:0]           in_byte,
  input  logic                 in_client_registered,
  output logic                 in_full,
  output logic                 sum_valid,
  output iltc_pkg::line_sum_t  sum_data,
  input  logic                 sum_full
);
  import iltc_pkg::*;

  localparam int unsigned LenW  = $clog2(MAX_LINE_BYTES + 1);
  localparam int unsigned CLenW = $clog2(CMD_CHARS + 2);
  localparam int unsigned CIdxW = $clog2(CMD_CHARS);

  typedef struct packed {
    scan_mode_t                mode;
    logic [LenW-1:0]           len;
    logic [4:0]                tok;
    logic [CMD_CHARS-1:0][7:0] cmd;
    logic [CLenW-1:0]          clen;
    logic [3:0][7:0]           sub;
    logic [3:0]                slen;
    logic [ParamW-1:0]         plen;
    logic                      nick;
    logic                      chan;
    logic                      trail;
    logic                      ovf;
  } scan_st_t;

  scan_mode_t mode_r, mode_nxt;
  logic pcr_r, pcr_nxt;
  logic [LenW-1:0] len_r, len_nxt;
  logic [4:0] tok_r, tok_nxt;
  logic [CMD_CHARS-1:0][7:0] cmd_r, cmd_nxt;
  logic [CLenW-1:0] clen_r, clen_nxt;
  logic [3:0][7:0] sub_r, sub_nxt;
  logic [3:0] slen_r, slen_nxt;
  logic [ParamW-1:0] plen_r, plen_nxt;
  logic nick_r, nick_nxt, chan_r, chan_nxt, trail_r, trail_nxt, ovf_r, ovf_nxt;

  logic go, fin;
  scan_st_t st_nxt;
  logic [4:0] kid;

  // One content byte through the tokenizer.
  function automatic scan_st_t scan_step(input scan_st_t s, input logic [7:0] b);
    scan_st_t n;
    logic ins;
    logic [4:0] tk;
    n = s;
    ins = 1'b0;
    tk = s.tok;
    if (s.len < LenW'(MAX_LINE_BYTES)) n.len = s.len + 1'b1;
    if (n.len > LenW'(MAX_LINE_BYTES - 2)) n.ovf = 1'b1;
    unique case (s.mode)
      MODE_GAP: begin
        if (!is_ws(b)) begin
          if (s.tok < 5'd31) n.tok = s.tok + 1'b1;
          tk = n.tok;
          if (b == ":") begin
            n.trail = 1'b1; n.mode = MODE_TRAIL;
          end else begin
            n.mode = MODE_TOKEN; ins = 1'b1;
          end
        end
      end
      MODE_TOKEN: begin
        if (is_ws(b)) n.mode = MODE_GAP;
        else ins = 1'b1;
      end
      MODE_TRAIL: begin
        if (b == 8'h0A) n.mode = MODE_SKIP;
        else ins = 1'b1;
      end
      MODE_SKIP: ;
      default: ;
    endcase
    if (ins) begin
      if (tk == 5'd1) begin
        if (s.clen < CLenW'(CMD_CHARS)) n.cmd[s.clen[CIdxW-1:0]] = upcase(b);
        if (s.clen <= CLenW'(CMD_CHARS)) n.clen = s.clen + 1'b1;
      end else if (tk == 5'd2) begin
        if (s.slen < 4'd4) n.sub[s.slen[1:0]] = upcase(b);
        if (s.slen <= 4'd4) n.slen = s.slen + 1'b1;
        if (s.plen == '0) begin
          n.nick = is_letter(b);
          n.chan = (b == "#") || (b == "&");
        end else begin
          if (!(is_letter(b) || (b >= "0" && b <= "9") || b == "-" || b == "_" ||
                b == "[" || b == "]")) n.nick = 1'b0;
          if (b == " " || b == "," || b == ":") n.chan = 1'b0;
        end
        if (s.plen < ParamW'(64)) n.plen = s.plen + 1'b1;
      end
    end
    return n;
  endfunction

  assign in_full = sum_full;
  assign go = in_push && !in_full;
  assign fin = go && pcr_r && (in_byte == 8'h0A);

  // Keyword match on the command buffer.
  always_comb begin
    kid = ID_UNKNOWN;
    if (clen_r == CLenW'(3) && cmd_r[0] == "C" && cmd_r[1] == "A" && cmd_r[2] == "P")
      kid = 5'd0;
    else if (clen_r == CLenW'(4) && cmd_r[0] == "P" && cmd_r[1] == "A" && cmd_r[2] == "S"
             && cmd_r[3] == "S") kid = 5'd1;
    else if (clen_r == CLenW'(4) && cmd_r[0] == "N" && cmd_r[1] == "I" && cmd_r[2] == "C"
             && cmd_r[3] == "K") kid = 5'd2;
    else if (clen_r == CLenW'(4) && cmd_r[0] == "U" && cmd_r[1] == "S" && cmd_r[2] == "E"
             && cmd_r[3] == "R") kid = 5'd3;
    else if (clen_r == CLenW'(4) && cmd_r[0] == "P" && cmd_r[1] == "I" && cmd_r[2] == "N"
             && cmd_r[3] == "G") kid = 5'd4;
    else if (clen_r == CLenW'(4) && cmd_r[0] == "J" && cmd_r[1] == "O" && cmd_r[2] == "I"
             && cmd_r[3] == "N") kid = 5'd5;
    else if (clen_r == CLenW'(4) && cmd_r[0] == "P" && cmd_r[1] == "A" && cmd_r[2] == "R"
             && cmd_r[3] == "T") kid = 5'd6;
    else if (clen_r == CLenW'(7) && cmd_r[0] == "P" && cmd_r[1] == "R" && cmd_r[2] == "I"
             && cmd_r[3] == "V" && cmd_r[4] == "M" && cmd_r[5] == "S" && cmd_r[6] == "G")
      kid = 5'd7;
    else if (clen_r == CLenW'(4) && cmd_r[0] == "K" && cmd_r[1] == "I" && cmd_r[2] == "C"
             && cmd_r[3] == "K") kid = 5'd8;
    else if (clen_r == CLenW'(6) && cmd_r[0] == "I" && cmd_r[1] == "N" && cmd_r[2] == "V"
             && cmd_r[3] == "I" && cmd_r[4] == "T" && cmd_r[5] == "E") kid = 5'd9;
    else if (clen_r == CLenW'(5) && cmd_r[0] == "T" && cmd_r[1] == "O" && cmd_r[2] == "P"
             && cmd_r[3] == "I" && cmd_r[4] == "C") kid = 5'd10;
    else if (clen_r == CLenW'(4) && cmd_r[0] == "M" && cmd_r[1] == "O" && cmd_r[2] == "D"
             && cmd_r[3] == "E") kid = 5'd11;
    else if (clen_r == CLenW'(4) && cmd_r[0] == "Q" && cmd_r[1] == "U" && cmd_r[2] == "I"
             && cmd_r[3] == "T") kid = 5'd12;
    else if (clen_r == CLenW'(3) && cmd_r[0] == "W" && cmd_r[1] == "H" && cmd_r[2] == "O")
      kid = 5'd13;
  end

  always_comb begin
    st_nxt.mode = mode_r; st_nxt.len = len_r; st_nxt.tok = tok_r; st_nxt.cmd = cmd_r;
    st_nxt.clen = clen_r; st_nxt.sub = sub_r; st_nxt.slen = slen_r; st_nxt.plen = plen_r;
    st_nxt.nick = nick_r; st_nxt.chan = chan_r; st_nxt.trail = trail_r; st_nxt.ovf = ovf_r;
    pcr_nxt = pcr_r;
    if (go) begin
      if (fin) begin
        st_nxt.mode = MODE_GAP; st_nxt.len = '0; st_nxt.tok = '0; st_nxt.clen = '0;
        st_nxt.slen = '0; st_nxt.plen = '0; st_nxt.nick = 1'b1; st_nxt.chan = 1'b1;
        st_nxt.trail = 1'b0; st_nxt.ovf = 1'b0;
        pcr_nxt = 1'b0;
      end else begin
        // A held CR that is not followed by LF is content: feed it ahead of the
        // current byte, then feed the current byte unless it is CR, which is held.
        if (pcr_r) st_nxt = scan_step(st_nxt, 8'h0D);
        pcr_nxt = (in_byte == 8'h0D);
        if (in_byte != 8'h0D) st_nxt = scan_step(st_nxt, in_byte);
      end
    end
    mode_nxt = st_nxt.mode; len_nxt = st_nxt.len; tok_nxt = st_nxt.tok;
    cmd_nxt = st_nxt.cmd; clen_nxt = st_nxt.clen; sub_nxt = st_nxt.sub;
    slen_nxt = st_nxt.slen; plen_nxt = st_nxt.plen; nick_nxt = st_nxt.nick;
    chan_nxt = st_nxt.chan; trail_nxt = st_nxt.trail; ovf_nxt = st_nxt.ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_GAP; pcr_r <= 1'b0; len_r <= '0; tok_r <= '0;
      clen_r <= '0; slen_r <= '0; plen_r <= '0; nick_r <= 1'b1;
      chan_r <= 1'b1; trail_r <= 1'b0; ovf_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt; pcr_r <= pcr_nxt; len_r <= len_nxt; tok_r <= tok_nxt;
      clen_r <= clen_nxt; slen_r <= slen_nxt; plen_r <= plen_nxt;
      nick_r <= nick_nxt; chan_r <= chan_nxt; trail_r <= trail_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    sub_r <= sub_nxt;
  end

  assign sum_valid = fin && (tok_r != '0);
  always_comb begin
    sum_data.cmd_id     = ovf_r ? ID_UNKNOWN : kid;
    sum_data.sub_len    = slen_r;
    sum_data.sub_chars  = sub_r;
    sum_data.has_param  = (tok_r >= 5'd2);
    sum_data.params     = (tok_r > 5'd16) ? 4'd15 : 4'(tok_r - 5'd1);
    sum_data.trailing   = trail_r;
    sum_data.nick_flag  = nick_r;
    sum_data.chan_flag  = chan_r;
    sum_data.param_len  = plen_r;
    sum_data.registered = in_client_registered;
    sum_data.overflow   = ovf_r;
  end
endmodule

// File: hdl/iltc_queue.sv
// Short queue between the scanner and the classifier.
module iltc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr,
  input  iltc_pkg::line_sum_t wdata,
  output logic                full,
  input  logic                rd,
  output iltc_pkg::line_sum_t rdata,
  output logic                empty
);
  import iltc_pkg::*;
  `include "irc_line_tokenizer_classifier_core_assert.svh"

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  line_sum_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;
  logic do_wr, do_rd;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_rd) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wdata;
  end

  `ILTC_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= (AW+1)'(DEPTH))
  `ILTC_ASSERT_NEXT(a_fill, clk, rst_n, do_wr && !do_rd, !empty)
  `ILTC_ASSERT_NEXT(a_drain, clk, rst_n, do_rd && !do_wr, !full)
endmodule

// File: hdl/iltc_classifier.sv
// Back end: turns a line summary into the result fields.
module iltc_classifier (
  input  iltc_pkg::line_sum_t sum,
  input  logic [5:0]          nick_max,
  input  logic [5:0]          chan_max,
  output logic [4:0]          command_id,
  output logic [2:0]          cap_sub,
  output logic [3:0]          param_count,
  output logic                has_trailing,
  output logic                first_nick_ok,
  output logic                first_chan_ok,
  output logic [2:0]          reply_kind,
  output logic                line_too_long
);
  import iltc_pkg::*;

  logic [3:0][7:0] s;
  assign s = sum.sub_chars;

  always_comb begin
    cap_sub = SUB_NONE;
    if (sum.cmd_id == ID_CAP && sum.has_param) begin
      if ((sum.sub_len == 4'd2 && s[0] == "L" && s[1] == "S") ||
          (sum.sub_len == 4'd4 && s[0] == "L" && s[1] == "I" && s[2] == "S" && s[3] == "T"))
        cap_sub = SUB_LS;
      else if (sum.sub_len == 4'd3 && s[0] == "R" && s[1] == "E" && s[2] == "Q")
        cap_sub = SUB_REQ;
      else if (sum.sub_len == 4'd3 && s[0] == "E" && s[1] == "N" && s[2] == "D")
        cap_sub = SUB_END;
      else cap_sub = SUB_OTHER;
    end
    if (sum.cmd_id == ID_CAP)
      reply_kind = (cap_sub == SUB_LS) ? RPL_CAP_LS :
                   (cap_sub == SUB_REQ) ? RPL_CAP_NAK : RPL_NONE;
    else if (sum.cmd_id <= ID_PING) reply_kind = RPL_DISPATCH;
    else if (!sum.registered) reply_kind = RPL_451;
    else reply_kind = (sum.cmd_id == ID_UNKNOWN) ? RPL_421 : RPL_DISPATCH;
  end

  assign command_id    = sum.cmd_id;
  assign param_count   = sum.params;
  assign has_trailing  = sum.trailing;
  assign line_too_long = sum.overflow;
  assign first_nick_ok = sum.has_param && sum.nick_flag && sum.param_len != '0 &&
                         sum.param_len <= {1'b0, nick_max};
  assign first_chan_ok = sum.has_param && sum.chan_flag && sum.param_len != '0 &&
                         sum.param_len <= {1'b0, chan_max};
endmodule

// File: hdl/irc_line_tokenizer_classifier_core.sv
// IRC line tokenizer/classifier top level.
// Usage:
//   Input queue (in_push/in_full): one received byte per transaction, with
//   in_client_registered sampled on the LF of a CR LF line end.
//   Result queue (out_empty/out_pop): one transaction per line that holds a
//   token, carrying the command id, CAP subcommand, parameter count, first
//   parameter checks, reply class and overlong flag.
//   Config port: APB writes to nick_max_len (0x0) and chan_max_len (0x4).
// Throughput: one byte per cycle while in_full is low; the scanner updates
//   its flags and small buffers as each byte is taken.
// Timing: a result appears in the cycle after the LF that ends its line;
//   it passes through a two-entry queue, and the classifier works on the
//   queue head combinationally.
// Reset: the scanner returns to line start and the queue empties; the
//   registers return to 9 and 50.
// Stall: when the queue holds two unread results, in_full rises and bytes
//   wait until a result is popped.
module irc_line_tokenizer_classifier_core #(
  parameter int unsigned MAX_LINE_BYTES = 512,
  parameter int unsigned CMD_CHARS      = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_byte,
  input  logic        in_client_registered,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [4:0]  out_command_id,
  output logic [2:0]  out_cap_sub,
  output logic [3:0]  out_param_count,
  output logic        out_has_trailing,
  output logic        out_first_nick_ok,
  output logic        out_first_chan_ok,
  output logic [2:0]  out_reply_kind,
  output logic        out_line_too_long,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import iltc_pkg::*;

  logic [5:0] nick_max_r, chan_max_r;
  logic sum_valid, q_full;
  line_sum_t sum_data, q_head;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nick_max_r <= 6'd9;
      chan_max_r <= 6'd50;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[2])
        REG_NICK_MAX: nick_max_r <= cfg_pwdata[5:0];
        REG_CHAN_MAX: chan_max_r <= cfg_pwdata[5:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (cfg_paddr[2])
      REG_NICK_MAX: cfg_prdata = {26'd0, nick_max_r};
      default:      cfg_prdata = {26'd0, chan_max_r};
    endcase
  end

  iltc_scanner #(.MAX_LINE_BYTES(MAX_LINE_BYTES), .CMD_CHARS(CMD_CHARS)) u_scan (
    .clk, .rst_n, .in_push, .in_byte, .in_client_registered, .in_full,
    .sum_valid, .sum_data, .sum_full(q_full)
  );

  iltc_queue #(.DEPTH(2)) u_q (
    .clk, .rst_n, .wr(sum_valid), .wdata(sum_data), .full(q_full),
    .rd(out_pop), .rdata(q_head), .empty(out_empty)
  );

  iltc_classifier u_cls (
    .sum(q_head), .nick_max(nick_max_r), .chan_max(chan_max_r),
    .command_id(out_command_id), .cap_sub(out_cap_sub),
    .param_count(out_param_count), .has_trailing(out_has_trailing),
    .first_nick_ok(out_first_nick_ok), .first_chan_ok(out_first_chan_ok),
    .reply_kind(out_reply_kind), .line_too_long(out_line_too_long)
  );
endmodule
